[rtl/core/bpdc_pkg.sv]
// Package for the button press duration classifier.
// Item, result and register types, codes and reset values; no dependencies.
`default_nettype none

package bpdc_pkg;

    localparam int TIME_W = 32;
    localparam int THR_W  = 16;
    localparam int CNT_W  = 16;
    localparam int IDX_W  = 2;

    typedef enum logic {
        OP_SAMPLE  = 1'b0,
        OP_CONSUME = 1'b1
    } t_op;

    typedef enum logic [IDX_W-1:0] {
        CFG_ACTIVE_LEVEL = 2'd0,
        CFG_MIN_PRESS    = 2'd1,
        CFG_LONG         = 2'd2,
        CFG_VERY_LONG    = 2'd3
    } t_cfg_idx;

    localparam logic             RST_ACTIVE_LEVEL = 1'b1;
    localparam logic [THR_W-1:0] RST_MIN_PRESS_MS = 16'd50;
    localparam logic [THR_W-1:0] RST_LONG_MS      = 16'd1000;
    localparam logic [THR_W-1:0] RST_VERY_LONG_MS = 16'd5000;

    typedef struct packed {
        t_op               op;
        logic [TIME_W-1:0] now_ms;
        logic              level;
    } t_item;

    typedef struct packed {
        logic              pressed;
        logic              held_long;
        logic              held_very_long;
        logic              released;
        logic              released_long;
        logic              released_very_long;
        logic [CNT_W-1:0]  press_total;
        logic [TIME_W-1:0] last_duration;
        logic [TIME_W-1:0] elapsed_ms;
        logic              consume_granted;
    } t_result;

    typedef struct packed {
        logic             active_level;
        logic [THR_W-1:0] min_press_ms;
        logic [THR_W-1:0] long_ms;
        logic [THR_W-1:0] very_long_ms;
    } t_cfg;

endpackage

`default_nettype wire

[rtl/core/bpdc_ifs.sv]
// Handshake interfaces of the classifier: input items, result items, register writes.
// Depends on bpdc_pkg for field widths.
`default_nettype none

interface bpdc_item_if;
    import bpdc_pkg::*;
    logic              valid;
    logic              ready;
    logic              op;
    logic [TIME_W-1:0] now_ms;
    logic              level;

    modport source (output valid, op, now_ms, level, input ready);
    modport sink   (input valid, op, now_ms, level, output ready);
endinterface

interface bpdc_result_if;
    import bpdc_pkg::*;
    logic              valid;
    logic              ready;
    logic              pressed;
    logic              held_long;
    logic              held_very_long;
    logic              released;
    logic              released_long;
    logic              released_very_long;
    logic [CNT_W-1:0]  press_total;
    logic [TIME_W-1:0] last_duration;
    logic [TIME_W-1:0] elapsed_ms;
    logic              consume_granted;

    modport source (output valid, pressed, held_long, held_very_long, released,
                    released_long, released_very_long, press_total, last_duration,
                    elapsed_ms, consume_granted, input ready);
    modport sink   (input valid, pressed, held_long, held_very_long, released,
                    released_long, released_very_long, press_total, last_duration,
                    elapsed_ms, consume_granted, output ready);
endinterface

interface bpdc_cfg_if;
    import bpdc_pkg::*;
    logic             valid;
    logic             ready;
    logic [IDX_W-1:0] index;
    logic [THR_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

[rtl/core/button_press_duration_classifier.sv]
// Top level of the button press duration classifier: input register, update core,
// result register and configuration registers. Depends on bpdc_pkg, bpdc_ifs.
//
// Usage:
//   i_item   : items {op, now_ms, level}; op sample updates the press state from the
//              level, op consume grants the current press at most once.
//   o_result : one result item per input item, in order, flags and counters taken
//              after the update.
//   i_cfg    : register writes {index, data}; always ready. Write only while idle.
// Path: an accepted item waits in the input register, is processed by the core on
//   advance and its result is held in the result register until it is taken.
// Throughput: one item per cycle while the result is taken; the state update is one
//   subtract and three threshold compares between the input and result registers.
// Reset (synchronous, active low): empties both registers, returns the state and
//   the thresholds to their defaults.
// Stall: while the result is not taken the input register still accepts one item;
//   i_item.ready then drops until the result register drains.
`default_nettype none

module button_press_duration_classifier (
    input  logic          i_clk,
    input  logic          i_rst_n,
    bpdc_item_if.sink     i_item,
    bpdc_result_if.source o_result,
    bpdc_cfg_if.sink      i_cfg
);
    import bpdc_pkg::*;

    logic    r_in_valid;
    t_item   r_in_item;
    logic    r_out_valid;
    t_result r_out_res;

    logic    advance;
    logic    in_ready;
    t_result core_res;
    t_cfg    cfg;

    assign advance  = r_in_valid && (!r_out_valid || o_result.ready);
    assign in_ready = !r_in_valid || advance;

    assign i_item.ready = in_ready;
    assign i_cfg.ready  = 1'b1;

    bpdc_cfg_regs u_cfg_regs (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_en    (i_cfg.valid),
        .i_wr_index (t_cfg_idx'(i_cfg.index)),
        .i_wr_data  (i_cfg.data),
        .o_cfg      (cfg)
    );

    bpdc_core u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (advance),
        .i_item    (r_in_item),
        .i_cfg     (cfg),
        .o_result  (core_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_ready) r_in_valid <= i_item.valid;
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (o_result.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_ready && i_item.valid) begin
            r_in_item.op     <= t_op'(i_item.op);
            r_in_item.now_ms <= i_item.now_ms;
            r_in_item.level  <= i_item.level;
        end
        if (advance) r_out_res <= core_res;
    end

    assign o_result.valid              = r_out_valid;
    assign o_result.pressed            = r_out_res.pressed;
    assign o_result.held_long          = r_out_res.held_long;
    assign o_result.held_very_long     = r_out_res.held_very_long;
    assign o_result.released           = r_out_res.released;
    assign o_result.released_long      = r_out_res.released_long;
    assign o_result.released_very_long = r_out_res.released_very_long;
    assign o_result.press_total        = r_out_res.press_total;
    assign o_result.last_duration      = r_out_res.last_duration;
    assign o_result.elapsed_ms         = r_out_res.elapsed_ms;
    assign o_result.consume_granted    = r_out_res.consume_granted;

endmodule

`default_nettype wire

[rtl/core/bpdc_cfg_regs.sv]
// Configuration register file of the classifier.
// Depends on bpdc_pkg.
`default_nettype none

module bpdc_cfg_regs (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_wr_en,
    input  bpdc_pkg::t_cfg_idx             i_wr_index,
    input  logic [bpdc_pkg::THR_W-1:0]     i_wr_data,
    output bpdc_pkg::t_cfg                 o_cfg
);
    import bpdc_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.active_level <= RST_ACTIVE_LEVEL;
            r_cfg.min_press_ms <= RST_MIN_PRESS_MS;
            r_cfg.long_ms      <= RST_LONG_MS;
            r_cfg.very_long_ms <= RST_VERY_LONG_MS;
        end else if (i_wr_en) begin
            unique case (i_wr_index)
                CFG_ACTIVE_LEVEL: r_cfg.active_level <= i_wr_data[0];
                CFG_MIN_PRESS:    r_cfg.min_press_ms <= i_wr_data;
                CFG_LONG:         r_cfg.long_ms      <= i_wr_data;
                CFG_VERY_LONG:    r_cfg.very_long_ms <= i_wr_data;
                default:          r_cfg              <= r_cfg;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

[rtl/core/bpdc_core.sv]
// Button state and single-pass update logic: takes one registered item per advance,
// updates the press state and forms the result. Depends on bpdc_pkg.
`default_nettype none

module bpdc_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_advance,
    input  bpdc_pkg::t_item   i_item,
    input  bpdc_pkg::t_cfg    i_cfg,
    output bpdc_pkg::t_result o_result
);
    import bpdc_pkg::*;

    logic              r_is_pressed,     n_is_pressed;
    logic              r_hold_long,      n_hold_long;
    logic              r_hold_very_long, n_hold_very_long;
    logic              r_rel,            n_rel;
    logic              r_rel_long,       n_rel_long;
    logic              r_rel_very_long,  n_rel_very_long;
    logic [CNT_W-1:0]  r_press_cnt,      n_press_cnt;
    logic              r_consumed,       n_consumed;
    logic [TIME_W-1:0] r_edge_time,      n_edge_time;
    logic [TIME_W-1:0] r_duration,       n_duration;

    logic [TIME_W-1:0] held;
    logic              gt_min, gt_long, gt_very_long;
    logic              is_active;
    logic              edge_set;
    logic              granted;

    // one wrapping subtract serves hold time, release duration and elapsed time
    assign held         = i_item.now_ms - r_edge_time;
    assign gt_min       = held > {{(TIME_W-THR_W){1'b0}}, i_cfg.min_press_ms};
    assign gt_long      = held > {{(TIME_W-THR_W){1'b0}}, i_cfg.long_ms};
    assign gt_very_long = held > {{(TIME_W-THR_W){1'b0}}, i_cfg.very_long_ms};
    assign is_active    = (i_item.level == i_cfg.active_level);

    always_comb begin
        n_is_pressed     = r_is_pressed;
        n_hold_long      = r_hold_long;
        n_hold_very_long = r_hold_very_long;
        n_rel            = r_rel;
        n_rel_long       = r_rel_long;
        n_rel_very_long  = r_rel_very_long;
        n_press_cnt      = r_press_cnt;
        n_consumed       = r_consumed;
        n_edge_time      = r_edge_time;
        n_duration       = r_duration;
        edge_set         = 1'b0;
        granted          = 1'b0;
        unique case (i_item.op)
            OP_SAMPLE: begin
                if (is_active) begin
                    if (!r_is_pressed) begin
                        n_is_pressed    = 1'b1;
                        n_rel           = 1'b0;
                        n_rel_long      = 1'b0;
                        n_rel_very_long = 1'b0;
                        n_press_cnt     = r_press_cnt + CNT_W'(1);
                        n_consumed      = 1'b0;
                        n_edge_time     = i_item.now_ms;
                        edge_set        = 1'b1;
                    end else begin
                        if (gt_long)      n_hold_long      = 1'b1;
                        if (gt_very_long) n_hold_very_long = 1'b1;
                    end
                end else if (r_is_pressed) begin
                    n_is_pressed     = 1'b0;
                    n_hold_long      = 1'b0;
                    n_hold_very_long = 1'b0;
                    n_duration       = held;
                    n_edge_time      = i_item.now_ms;
                    edge_set         = 1'b1;
                    if (gt_min) begin
                        n_rel = 1'b1;
                        if (gt_long)      n_rel_long      = 1'b1;
                        if (gt_very_long) n_rel_very_long = 1'b1;
                    end else begin
                        n_press_cnt = r_press_cnt - CNT_W'(1);
                    end
                end else begin
                    n_rel           = 1'b0;
                    n_rel_long      = 1'b0;
                    n_rel_very_long = 1'b0;
                end
            end
            OP_CONSUME: begin
                if (!r_consumed && r_is_pressed) begin
                    n_consumed = 1'b1;
                    granted    = 1'b1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_is_pressed     <= 1'b0;
            r_hold_long      <= 1'b0;
            r_hold_very_long <= 1'b0;
            r_rel            <= 1'b1;
            r_rel_long       <= 1'b0;
            r_rel_very_long  <= 1'b0;
            r_press_cnt      <= '0;
            r_consumed       <= 1'b0;
            r_edge_time      <= '0;
            r_duration       <= '0;
        end else if (i_advance) begin
            r_is_pressed     <= n_is_pressed;
            r_hold_long      <= n_hold_long;
            r_hold_very_long <= n_hold_very_long;
            r_rel            <= n_rel;
            r_rel_long       <= n_rel_long;
            r_rel_very_long  <= n_rel_very_long;
            r_press_cnt      <= n_press_cnt;
            r_consumed       <= n_consumed;
            r_edge_time      <= n_edge_time;
            r_duration       <= n_duration;
        end
    end

    always_comb begin
        o_result.pressed            = n_is_pressed;
        o_result.held_long          = n_hold_long;
        o_result.held_very_long     = n_hold_very_long;
        o_result.released           = n_rel;
        o_result.released_long      = n_rel_long;
        o_result.released_very_long = n_rel_very_long;
        o_result.press_total        = n_press_cnt;
        o_result.last_duration      = n_duration;
        // edge restamped to now gives zero elapsed time
        o_result.elapsed_ms         = edge_set ? '0 : held;
        o_result.consume_granted    = granted;
    end

    a_hold_only_pressed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_is_pressed |-> (!r_hold_long && !r_hold_very_long))
        else $error("hold flag set while released");

    a_no_release_while_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_is_pressed |-> (!r_rel && !r_rel_long && !r_rel_very_long))
        else $error("release flag set during a press");

    a_release_marks_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_rel_long || r_rel_very_long) |-> r_rel)
        else $error("release mark without valid release");

    a_grant_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_advance && granted) |=> (r_consumed && r_is_pressed))
        else $error("grant did not mark press consumed");

endmodule

`default_nettype wire

[tb/button_press_duration_classifier_test.sv]
// Testbench for button_press_duration_classifier: directed and random press sequences,
// each result item checked field by field against a cycle-free predictor.
// Depends on bpdc_pkg, bpdc_ifs and the classifier RTL.
`timescale 1ns / 100ps

module button_press_duration_classifier_test;
    import bpdc_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int PHASE_ITEMS    = 300;
    localparam int PHASES         = 5;
    localparam int MAX_REPORTS    = 40;
    localparam int PRESS_ROUNDS   = 20;

    logic i_clk;
    logic i_rst_n;

    bpdc_item_if   item_bus();
    bpdc_result_if result_bus();
    bpdc_cfg_if    cfg_bus();

    button_press_duration_classifier u_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (item_bus),
        .o_result (result_bus),
        .i_cfg    (cfg_bus)
    );

    // predictor copy of the thresholds and the press state
    t_cfg              cur_cfg;
    logic              btn_down;
    logic              hold_long;
    logic              hold_vlong;
    logic              rel;
    logic              rel_long;
    logic              rel_vlong;
    logic              consumed;
    logic [CNT_W-1:0]  press_cnt;
    logic [TIME_W-1:0] edge_ms;
    logic [TIME_W-1:0] dur_ms;

    t_result           pending_results[$];
    t_result           want;
    logic [TIME_W-1:0] clock_ms;
    bit                quiet_bus;
    int unsigned       stall_left;
    int unsigned       idle_cycles;
    int unsigned       mismatch_count;
    int unsigned       items_sent;
    int unsigned       results_checked;
    int unsigned       reg_writes;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    function automatic t_result classify_item(input t_item it);
        t_result           r;
        logic [TIME_W-1:0] span;
        logic              grant;
        grant = 1'b0;
        if (it.op == OP_SAMPLE) begin
            if (it.level == cur_cfg.active_level) begin
                if (!btn_down) begin
                    btn_down  = 1'b1;
                    rel       = 1'b0;
                    rel_long  = 1'b0;
                    rel_vlong = 1'b0;
                    press_cnt = press_cnt + 16'd1;
                    consumed  = 1'b0;
                    edge_ms   = it.now_ms;
                end else begin
                    span = it.now_ms - edge_ms;
                    if (span > cur_cfg.long_ms)
                        hold_long = 1'b1;
                    if (span > cur_cfg.very_long_ms)
                        hold_vlong = 1'b1;
                end
            end else if (btn_down) begin
                btn_down   = 1'b0;
                hold_long  = 1'b0;
                hold_vlong = 1'b0;
                dur_ms     = it.now_ms - edge_ms;
                edge_ms    = it.now_ms;
                if (dur_ms > cur_cfg.min_press_ms) begin
                    rel = 1'b1;
                    if (dur_ms > cur_cfg.long_ms)
                        rel_long = 1'b1;
                    if (dur_ms > cur_cfg.very_long_ms)
                        rel_vlong = 1'b1;
                end else begin
                    // too short to count: take the press back
                    press_cnt = press_cnt - 16'd1;
                end
            end else begin
                rel       = 1'b0;
                rel_long  = 1'b0;
                rel_vlong = 1'b0;
            end
        end else if (!consumed && btn_down) begin
            consumed = 1'b1;
            grant    = 1'b1;
        end
        r.pressed            = btn_down;
        r.held_long          = hold_long;
        r.held_very_long     = hold_vlong;
        r.released           = rel;
        r.released_long      = rel_long;
        r.released_very_long = rel_vlong;
        r.press_total        = press_cnt;
        r.last_duration      = dur_ms;
        r.elapsed_ms         = it.now_ms - edge_ms;
        r.consume_granted    = grant;
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
            $display("MISMATCH at %0t ns: %s", $time, msg);
    endtask

    task automatic compare_field(input string field, input logic [31:0] got,
                                 input logic [31:0] exp_val);
        if (got !== exp_val)
            report_mismatch($sformatf("result %0d %s: got 0x%0h, want 0x%0h",
                                      results_checked, field, got, exp_val));
    endtask

    // result checker and receiver stall generator
    always @(posedge i_clk) begin
        if (i_rst_n && result_bus.valid && result_bus.ready) begin
            if (pending_results.size() == 0) begin
                report_mismatch("result item with no expectation pending");
            end else begin
                want = pending_results.pop_front();
                compare_field("pressed", 32'(result_bus.pressed), 32'(want.pressed));
                compare_field("held_long", 32'(result_bus.held_long),
                              32'(want.held_long));
                compare_field("held_very_long", 32'(result_bus.held_very_long),
                              32'(want.held_very_long));
                compare_field("released", 32'(result_bus.released), 32'(want.released));
                compare_field("released_long", 32'(result_bus.released_long),
                              32'(want.released_long));
                compare_field("released_very_long", 32'(result_bus.released_very_long),
                              32'(want.released_very_long));
                compare_field("press_total", 32'(result_bus.press_total),
                              32'(want.press_total));
                compare_field("last_duration", result_bus.last_duration, want.last_duration);
                compare_field("elapsed_ms", result_bus.elapsed_ms, want.elapsed_ms);
                compare_field("consume_granted", 32'(result_bus.consume_granted),
                              32'(want.consume_granted));
                results_checked++;
            end
        end
        if (quiet_bus) begin
            stall_left = 0;
            result_bus.ready <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left--;
            result_bus.ready <= 1'b0;
        end else if ($urandom_range(0, 9) == 0) begin
            stall_left = $urandom_range(0, 15);
            result_bus.ready <= 1'b0;
        end else begin
            result_bus.ready <= 1'b1;
        end
    end

    initial begin
        idle_cycles = 0;
        while (idle_cycles < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((item_bus.valid && item_bus.ready) || (result_bus.valid && result_bus.ready)
                || (cfg_bus.valid && cfg_bus.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("Timeout: %0d cycles without a handshake, %0d results outstanding",
                 WATCHDOG_LIMIT, pending_results.size());
        $display("== FAIL ==");
        $finish;
    end

    // Sends one item; valid stays high afterwards so back-to-back items need no gap.
    task automatic send_item(input t_op op, input logic [TIME_W-1:0] stamp, input logic lvl);
        t_item it;
        if (!quiet_bus && $urandom_range(0, 7) == 0) begin
            item_bus.valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge i_clk);
        end
        it.op     = op;
        it.now_ms = stamp;
        it.level  = lvl;
        item_bus.valid  <= 1'b1;
        item_bus.op     <= op;
        item_bus.now_ms <= stamp;
        item_bus.level  <= lvl;
        do @(posedge i_clk); while (!item_bus.ready);
        pending_results.push_back(classify_item(it));
        items_sent++;
    endtask

    task automatic wait_drained();
        item_bus.valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (3) @(posedge i_clk);
    endtask

    // Writes all four registers; only called with nothing in flight.
    task automatic apply_settings(input t_cfg c);
        logic [THR_W-1:0] wdata;
        t_cfg_idx         idx;
        int               k;
        for (k = 0; k < 4; k++) begin
            idx   = t_cfg_idx'(k);
            wdata = THR_W'($urandom);
            case (idx)
                CFG_ACTIVE_LEVEL: wdata[0] = c.active_level;   // upper bits unused
                CFG_MIN_PRESS:    wdata = c.min_press_ms;
                CFG_LONG:         wdata = c.long_ms;
                CFG_VERY_LONG:    wdata = c.very_long_ms;
                default:          wdata = '0;
            endcase
            cfg_bus.valid <= 1'b1;
            cfg_bus.index <= idx;
            cfg_bus.data  <= wdata;
            do @(posedge i_clk); while (!cfg_bus.ready);
            reg_writes++;
        end
        cfg_bus.valid <= 1'b0;
        cur_cfg = c;
    endtask

    task automatic test_default_settings();
        send_item(OP_SAMPLE, 32'd0, 1'b0);              // idle sample clears the reset release
        send_item(OP_CONSUME, 32'hFFFF_FFFF, 1'b1);     // nothing held, no grant
        send_item(OP_SAMPLE, 32'd100, 1'b1);
        send_item(OP_CONSUME, 32'd150, 1'b0);
        send_item(OP_CONSUME, 32'd160, 1'b1);           // second consume of the same press
        send_item(OP_SAMPLE, 32'd1100, 1'b1);           // exactly on the long threshold
        send_item(OP_SAMPLE, 32'd1101, 1'b1);
        send_item(OP_SAMPLE, 32'd5101, 1'b1);
        send_item(OP_SAMPLE, 32'd6100, 1'b0);
        send_item(OP_SAMPLE, 32'd6200, 1'b0);
        send_item(OP_SAMPLE, 32'd6300, 1'b1);
        send_item(OP_SAMPLE, 32'd6350, 1'b0);           // on the minimum: count goes back
        send_item(OP_SAMPLE, 32'hFFFF_FFF0, 1'b1);      // press across the time wrap
        send_item(OP_SAMPLE, 32'h0000_0100, 1'b0);
    endtask

    task automatic test_threshold_extremes();
        t_cfg c;
        wait_drained();
        c.active_level = 1'b0;
        c.min_press_ms = '0;
        c.long_ms      = '0;
        c.very_long_ms = '0;
        apply_settings(c);
        send_item(OP_SAMPLE, 32'd20000, 1'b0);
        send_item(OP_SAMPLE, 32'd20000, 1'b0);
        send_item(OP_SAMPLE, 32'd20001, 1'b0);
        send_item(OP_SAMPLE, 32'd20001, 1'b1);
        send_item(OP_SAMPLE, 32'd20005, 1'b0);
        send_item(OP_SAMPLE, 32'd20005, 1'b1);          // zero length press
        wait_drained();
        c.active_level = 1'b1;
        c.min_press_ms = '1;
        c.long_ms      = '1;
        c.very_long_ms = '1;
        apply_settings(c);
        send_item(OP_SAMPLE, 32'd0, 1'b1);
        send_item(OP_SAMPLE, 32'd65535, 1'b1);
        send_item(OP_SAMPLE, 32'd65536, 1'b1);
        send_item(OP_CONSUME, 32'd65537, 1'b0);
        // swap the active level mid-press: the held level now reads as released
        wait_drained();
        c.active_level = 1'b0;
        apply_settings(c);
        send_item(OP_SAMPLE, 32'hFFFF_FFFF, 1'b0);
        send_item(OP_SAMPLE, 32'hFFFF_FFFF, 1'b1);
        wait_drained();
        c.active_level = 1'b1;
        apply_settings(c);
        send_item(OP_SAMPLE, 32'd10, 1'b1);
        send_item(OP_SAMPLE, 32'd65545, 1'b0);          // 65535 ms, not above the minimum
        clock_ms = 32'd100000;
    endtask

    // Counts a run of valid presses up, then a zero length press that is taken back, then one more valid press.
    task automatic test_press_count();
        t_cfg c;
        wait_drained();
        c.active_level = 1'b1;
        c.min_press_ms = 16'd0;
        c.long_ms      = 16'd3;
        c.very_long_ms = 16'd7;
        apply_settings(c);
        quiet_bus = 1'b1;
        repeat (PRESS_ROUNDS) begin
            send_item(OP_SAMPLE, clock_ms, 1'b1);
            send_item(OP_SAMPLE, clock_ms + $urandom_range(1, 9), 1'b0);
            clock_ms = clock_ms + 32'd10;
        end
        send_item(OP_SAMPLE, clock_ms, 1'b1);
        send_item(OP_SAMPLE, clock_ms, 1'b0);
        send_item(OP_SAMPLE, clock_ms + 32'd1, 1'b1);
        send_item(OP_SAMPLE, clock_ms + 32'd5, 1'b0);
        clock_ms = clock_ms + 32'd10;
        quiet_bus = 1'b0;
    endtask

    task automatic test_random_sessions();
        t_cfg              c;
        logic [TIME_W-1:0] start_ms;
        logic [TIME_W-1:0] dur;
        logic [TIME_W-1:0] off;
        logic              act;
        int unsigned       phase_end;
        bit                paused;
        int                p;
        paused = 1'b0;
        for (p = 0; p < PHASES; p++) begin
            wait_drained();
            if ($urandom_range(0, 3) == 0) begin
                c.min_press_ms = $urandom_range(0, 1) ? '1 : '0;
                c.long_ms      = $urandom_range(0, 1) ? '1 : '0;
                c.very_long_ms = $urandom_range(0, 1) ? '1 : '0;
            end else begin
                c.min_press_ms = THR_W'($urandom_range(0, 200));
                c.long_ms      = THR_W'($urandom_range(0, 3000));
                c.very_long_ms = THR_W'($urandom_range(0, 9000));
            end
            c.active_level = 1'($urandom_range(0, 1));
            apply_settings(c);
            quiet_bus = (p == PHASES - 1);
            phase_end = items_sent + PHASE_ITEMS;
            while (items_sent < phase_end) begin
                if (p == 0 && !paused && items_sent + PHASE_ITEMS / 2 >= phase_end) begin
                    wait_drained();
                    paused = 1'b1;
                end
                if ($urandom_range(0, 9) == 0) begin
                    send_item(t_op'($urandom_range(0, 1)), $urandom,
                              1'($urandom_range(0, 1)));
                end else begin
                    if ($urandom_range(0, 19) == 0)
                        clock_ms = 32'hFFFF_FFFF - $urandom_range(0, 20000);
                    act = cur_cfg.active_level;
                    // aim the press length at a threshold edge in three of ten cases
                    case ($urandom_range(0, 9))
                        0:       dur = cur_cfg.min_press_ms + $urandom_range(0, 2) - 1;
                        1:       dur = cur_cfg.long_ms + $urandom_range(0, 2) - 1;
                        2:       dur = cur_cfg.very_long_ms + $urandom_range(0, 2) - 1;
                        3:       dur = $urandom;
                        default: dur = $urandom_range(0, cur_cfg.very_long_ms + 2000);
                    endcase
                    start_ms = clock_ms;
                    send_item(OP_SAMPLE, start_ms, act);
                    off = '0;
                    repeat ($urandom_range(0, 4)) begin
                        off = off + $urandom_range(0, dur - off);
                        if ($urandom_range(0, 3) == 0)
                            send_item(OP_CONSUME, start_ms + off, 1'($urandom_range(0, 1)));
                        else
                            send_item(OP_SAMPLE, start_ms + off, act);
                    end
                    send_item(OP_SAMPLE, start_ms + dur, !act);
                    repeat ($urandom_range(0, 2))
                        send_item(t_op'($urandom_range(0, 1)),
                                  start_ms + dur + $urandom_range(0, 100), !act);
                    clock_ms = start_ms + dur + $urandom_range(1, 500);
                end
            end
        end
    endtask

    initial begin
        i_rst_n           = 1'b0;
        item_bus.valid    = 1'b0;
        item_bus.op       = 1'b0;
        item_bus.now_ms   = '0;
        item_bus.level    = 1'b0;
        result_bus.ready  = 1'b0;
        cfg_bus.valid     = 1'b0;
        cfg_bus.index     = '0;
        cfg_bus.data      = '0;
        quiet_bus         = 1'b0;
        stall_left        = 0;
        mismatch_count    = 0;
        items_sent        = 0;
        results_checked   = 0;
        reg_writes        = 0;
        clock_ms          = '0;
        cur_cfg.active_level = RST_ACTIVE_LEVEL;
        cur_cfg.min_press_ms = RST_MIN_PRESS_MS;
        cur_cfg.long_ms      = RST_LONG_MS;
        cur_cfg.very_long_ms = RST_VERY_LONG_MS;
        btn_down   = 1'b0;
        hold_long  = 1'b0;
        hold_vlong = 1'b0;
        rel        = 1'b1;
        rel_long   = 1'b0;
        rel_vlong  = 1'b0;
        consumed   = 1'b0;
        press_cnt  = '0;
        edge_ms    = '0;
        dur_ms     = '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_default_settings();
        test_threshold_extremes();
        test_press_count();
        test_random_sessions();
        wait_drained();

        $display("Covered %0d items: directed edges, press counting, %0d random phases;",
                 items_sent, PHASES);
        $display("%0d results checked, %0d register writes, %0d mismatches.",
                 results_checked, reg_writes, mismatch_count);
        if (mismatch_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
